@@ hw/rtl/tlg_pkg.sv @@
// shared constants, types and helpers for the toroidal life grid engine
package tlg_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MIN_SIZE   = 4;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int SIZE_W = 9;
  localparam int MASK_W = 9;
  localparam int POP_W  = 17;
  localparam int CMD_W  = 3;
  localparam int REG_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SET     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INVERT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [REG_W-1:0] REG_WIDTH   = 2'd0;
  localparam logic [REG_W-1:0] REG_HEIGHT  = 2'd1;
  localparam logic [REG_W-1:0] REG_BIRTH   = 2'd2;
  localparam logic [REG_W-1:0] REG_SURVIVE = 2'd3;

  // one column of the 3x3 neighborhood
  typedef struct packed {
    logic above;
    logic center;
    logic below;
  } nbr_col_t;

  typedef struct packed {
    nbr_col_t left;
    nbr_col_t mid;
    nbr_col_t right;
  } window_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s < SIZE_W'(MIN_SIZE)) s = SIZE_W'(MIN_SIZE);
    if (s > maxv) s = maxv;
    return s;
  endfunction

endpackage

@@ hw/rtl/tlg_rule.sv @@
// neighbor count and birth/survive lookup for one cell
module tlg_rule import tlg_pkg::*; (
  input  window_t           win,
  input  logic [MASK_W-1:0] birth_mask,
  input  logic [MASK_W-1:0] survive_mask,
  output logic              next_alive
);

  logic [3:0]        cnt;
  logic [MASK_W-1:0] mask;

  assign cnt = {3'b0, win.left.above}  + {3'b0, win.mid.above}  + {3'b0, win.right.above}
             + {3'b0, win.left.center} + {3'b0, win.right.center}
             + {3'b0, win.left.below}  + {3'b0, win.mid.below}  + {3'b0, win.right.below};

  assign mask       = win.mid.center ? survive_mask : birth_mask;
  assign next_alive = mask[cnt];

endmodule

@@ hw/rtl/toroidal_life_grid_engine_top.sv @@
// top level of the toroidal life grid engine: command sequencer and cell memories
// set and read pass through a read-modify-write state before the result; undefined codes report directly
// advance copies row h-1, then sweeps the grid row by row, one cell per cycle
// invert is a read-modify-write sweep over the grid in use; clear sweeps the whole cell memory
// reset and any size change run a clearing pass with in_stall high
// one command at a time; the next may be taken while the previous result waits
module toroidal_life_grid_engine_top import tlg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration writes
  input  logic              cfg_write,
  input  logic [REG_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  // command channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [COL_W-1:0]  x_coord,
  input  logic [ROW_W-1:0]  y_coord,
  input  logic              cell_value,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              read_value,
  output logic              in_range,
  output logic [POP_W-1:0]  population
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RMW  = 3'd1;
  localparam logic [2:0] S_COPY = 3'd2;
  localparam logic [2:0] S_ROW  = 3'd3;
  localparam logic [2:0] S_INV  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;

  // configuration
  logic [SIZE_W-1:0] grid_w, grid_h;
  logic [MASK_W-1:0] birth, survive;
  logic [SIZE_W-1:0] size_clamped;

  // counts
  logic [POP_W-1:0] live, pop, area;

  // latched command
  logic [CMD_W-1:0] cmd_q;
  logic [COL_W-1:0] x_q;
  logic [ROW_W-1:0] y_q;
  logic             v_q, inr_q, rdv_q, reply;

  // sweep control
  logic [SIZE_W-1:0] k;
  logic [ROW_W-1:0]  y;
  logic              sweep_done;
  logic [ADDR_W-1:0] clr_cnt;

  // pending write for copy and invert sweeps
  logic              pv;
  logic [ADDR_W-1:0] paddr;

  // generation pipeline: issue, window shift, compute
  logic              iss_v;
  logic [SIZE_W-1:0] iss_k;
  logic [COL_W-1:0]  iss_col;
  logic              cmp_v;
  logic [COL_W-1:0]  cmp_x;
  window_t           win;
  nbr_col_t          zcol, arr;
  logic              pp;
  logic              nxt;

  // memories
  logic cell_mem  [MAX_WIDTH*MAX_HEIGHT];
  logic row_mem   [2*MAX_WIDTH];
  logic first_mem [MAX_WIDTH];
  logic cell_q1, cell_q2, row_q, first_q;

  logic [ADDR_W-1:0] cr_addr1, cr_addr2, cw_addr;
  logic              cw_en, cw_data;
  logic [COL_W:0]    rw_addr;
  logic              rw_en;
  logic              fw_en;

  logic [SIZE_W-1:0] last_col, last_row;
  logic [COL_W-1:0]  row_col;
  logic              on_last_row, ok_in, in_fire, out_free;

  assign last_col    = grid_w - 9'd1;
  assign last_row    = grid_h - 9'd1;
  assign on_last_row = ({1'b0, y} == last_row);
  assign ok_in       = ({1'b0, x_coord} < grid_w) && ({1'b0, y_coord} < grid_h);
  assign in_stall    = rst || (state != S_IDLE);
  assign in_fire     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign area        = {8'b0, grid_w} * {8'b0, grid_h};
  assign size_clamped = clamp_size(cfg_data,
                                   (cfg_index == REG_WIDTH) ? SIZE_W'(MAX_WIDTH)
                                                            : SIZE_W'(MAX_HEIGHT));

  // each row reads column w-1 first for the left wrap, then 0 .. w-1
  assign row_col = (k == '0) ? last_col[COL_W-1:0] : COL_W'(k - 9'd1);

  // new column entering the window; the extra step past the row end reuses column 0
  always_comb begin
    if (iss_k == grid_w + 9'd1) begin
      arr = zcol;
    end else begin
      arr.above  = row_q;
      arr.center = cell_q1;
      arr.below  = on_last_row ? first_q : cell_q2;
    end
  end

  tlg_rule u_rule (
    .win          (win),
    .birth_mask   (birth),
    .survive_mask (survive),
    .next_alive   (nxt)
  );

  // cell memory read addresses
  always_comb begin
    case (state)
      S_IDLE:  cr_addr1 = {y_coord, x_coord};
      S_COPY:  cr_addr1 = {last_row[ROW_W-1:0], k[COL_W-1:0]};
      S_ROW:   cr_addr1 = {y, row_col};
      default: cr_addr1 = {y, k[COL_W-1:0]};
    endcase
    cr_addr2 = {y + 8'd1, row_col};
  end

  // cell memory write port
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = {y, cmp_x};
    cw_data = nxt;
    case (state)
      S_RMW: begin
        cw_en   = (cmd_q == CMD_SET) && inr_q;
        cw_addr = {y_q, x_q};
        cw_data = v_q;
      end
      S_ROW: begin
        cw_en = cmp_v;
      end
      S_INV: begin
        cw_en   = pv;
        cw_addr = paddr;
        cw_data = ~cell_q1;
      end
      S_CLR: begin
        cw_en   = 1'b1;
        cw_addr = clr_cnt;
        cw_data = 1'b0;
      end
      default: cw_en = 1'b0;
    endcase
  end

  // row buffer: copy of row h-1 goes to bank pp, original of each row to the other bank
  always_comb begin
    rw_en   = 1'b0;
    rw_addr = {pp, paddr[COL_W-1:0]};
    if (state == S_COPY) begin
      rw_en = pv;
    end else if (state == S_ROW) begin
      rw_en   = iss_v && (iss_k <= grid_w);
      rw_addr = {~pp, iss_col};
    end
  end
  assign fw_en = (state == S_ROW) && (y == '0) && iss_v && (iss_k <= grid_w);

  always_ff @(posedge clk) begin
    if (cw_en) cell_mem[cw_addr] <= cw_data;
    cell_q1 <= cell_mem[cr_addr1];
    cell_q2 <= cell_mem[cr_addr2];
  end

  always_ff @(posedge clk) begin
    if (rw_en) row_mem[rw_addr] <= cell_q1;
    row_q <= row_mem[{pp, row_col}];
  end

  always_ff @(posedge clk) begin
    if (fw_en) first_mem[iss_col] <= cell_q1;
    first_q <= first_mem[row_col];
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      reply      <= 1'b0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      grid_w     <= SIZE_W'(MAX_WIDTH);
      grid_h     <= SIZE_W'(MAX_HEIGHT);
      birth      <= 9'd8;
      survive    <= 9'd12;
      live       <= '0;
      pv         <= 1'b0;
      iss_v      <= 1'b0;
      cmp_v      <= 1'b0;
      pp         <= 1'b0;
      sweep_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q <= command;
            x_q   <= x_coord;
            y_q   <= y_coord;
            v_q   <= cell_value;
            inr_q <= ok_in && ((command == CMD_SET) || (command == CMD_READ));
            rdv_q <= 1'b0;
            reply <= 1'b1;
            case (command) inside
              CMD_SET, CMD_READ: state <= S_RMW;
              CMD_ADVANCE: begin
                state <= S_COPY;
                k     <= '0;
                pop   <= '0;
              end
              CMD_INVERT: begin
                state      <= S_INV;
                k          <= '0;
                y          <= '0;
                sweep_done <= 1'b0;
              end
              CMD_CLEAR: begin
                state   <= S_CLR;
                clr_cnt <= '0;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_RMW: begin
          if ((cmd_q == CMD_SET) && inr_q) begin
            live <= live - {16'b0, cell_q1} + {16'b0, v_q};
          end
          rdv_q <= (cmd_q == CMD_READ) && inr_q && cell_q1;
          state <= S_DONE;
        end

        S_COPY: begin
          pv <= 1'b0;
          if (k < grid_w) begin
            pv    <= 1'b1;
            paddr <= {last_row[ROW_W-1:0], k[COL_W-1:0]};
            k     <= k + 9'd1;
          end else if (!pv) begin
            state <= S_ROW;
            k     <= '0;
            y     <= '0;
          end
        end

        S_ROW: begin
          iss_v <= 1'b0;
          if (k <= grid_w + 9'd1) begin
            iss_v   <= 1'b1;
            iss_k   <= k;
            iss_col <= row_col;
            k       <= k + 9'd1;
          end
          if (iss_v) begin
            win.left  <= win.mid;
            win.mid   <= win.right;
            win.right <= arr;
            if (iss_k == 9'd1) zcol <= arr;
            cmp_v <= (iss_k >= 9'd2);
            cmp_x <= COL_W'(iss_k - 9'd2);
          end else begin
            cmp_v <= 1'b0;
          end
          if (cmp_v) pop <= pop + {16'b0, nxt};
          if ((k == grid_w + 9'd2) && !iss_v && !cmp_v) begin
            pp <= ~pp;
            k  <= '0;
            if (on_last_row) begin
              live  <= pop;
              state <= S_DONE;
            end else begin
              y <= y + 8'd1;
            end
          end
        end

        S_INV: begin
          pv <= 1'b0;
          if (!sweep_done) begin
            pv    <= 1'b1;
            paddr <= {y, k[COL_W-1:0]};
            if (k == last_col) begin
              k <= '0;
              if (on_last_row) sweep_done <= 1'b1;
              else             y <= y + 8'd1;
            end else begin
              k <= k + 9'd1;
            end
          end else if (!pv) begin
            live  <= area - live;
            state <= S_DONE;
          end
        end

        S_CLR: begin
          clr_cnt <= clr_cnt + 16'd1;
          if (clr_cnt == '1) begin
            live  <= '0;
            state <= reply ? S_DONE : S_IDLE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            read_value <= rdv_q;
            in_range   <= inr_q;
            population <= live;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // register writes; a size change restarts the clearing pass without a result
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WIDTH: begin
            if (size_clamped != grid_w) begin
              grid_w  <= size_clamped;
              live    <= '0;
              clr_cnt <= '0;
              reply   <= 1'b0;
              state   <= S_CLR;
            end
          end
          REG_HEIGHT: begin
            if (size_clamped != grid_h) begin
              grid_h  <= size_clamped;
              live    <= '0;
              clr_cnt <= '0;
              reply   <= 1'b0;
              state   <= S_CLR;
            end
          end
          REG_BIRTH:   birth   <= cfg_data;
          REG_SURVIVE: survive <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // population never exceeds the cells in use
  a_live_bound: assert property (@(posedge clk) disable iff (rst) live <= area)
    else $error("population above grid area");

  // results are only produced from the finishing state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside finishing state");

  // generation writes stay inside the columns in use
  a_gen_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW) && cmp_v |-> {1'b0, cmp_x} < grid_w)
    else $error("generation write outside grid");

  // an accepted command always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("command accepted but sequencer stayed idle");

endmodule

@@ tb/toroidal_life_grid_engine_top_tb.sv @@
// testbench for the toroidal life grid engine: random commands checked against a grid predictor
`timescale 1ns / 100ps

module toroidal_life_grid_engine_top_tb;
  import tlg_pkg::*;

  // codes 5 to 7 are not decoded by the block
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam int IDLE_LIMIT = 300000;

  // grid predictor and store of expected results
  class life_grid_scoreboard;
    typedef struct {
      bit        rd;
      bit        inr;
      bit [16:0] pop;
    } grid_result_t;

    bit cells [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    bit next_cells [0:MAX_HEIGHT-1][0:MAX_WIDTH-1];
    int unsigned live;
    int unsigned width;
    int unsigned height;
    bit [8:0] birth;
    bit [8:0] survive;
    grid_result_t expected_q[$];
    int mismatches;
    int failures;
    int commands_seen;
    int results_seen;

    function new();
      width = MAX_WIDTH;
      height = MAX_HEIGHT;
      birth = 9'd8;
      survive = 9'd12;
      mismatches = 0;
      failures = 0;
      commands_seen = 0;
      results_seen = 0;
      clear_grid();
    endfunction

    function void clear_grid();
      cells = '{default: '0};
      live = 0;
    endfunction

    function int unsigned clamp_dim(bit [8:0] v, int unsigned maxv);
      int unsigned s;
      s = v;
      if (s < MIN_SIZE) s = MIN_SIZE;
      if (s > maxv) s = maxv;
      return s;
    endfunction

    function void write_reg(logic [REG_W-1:0] idx, bit [8:0] d);
      int unsigned s;
      case (idx)
        REG_WIDTH: begin
          s = clamp_dim(d, MAX_WIDTH);
          if (s != width) begin
            width = s;
            clear_grid();
          end
        end
        REG_HEIGHT: begin
          s = clamp_dim(d, MAX_HEIGHT);
          if (s != height) begin
            height = s;
            clear_grid();
          end
        end
        REG_BIRTH: birth = d;
        REG_SURVIVE: survive = d;
        default: ;
      endcase
    endfunction

    // one generation over the wrapped area in use
    function void step_generation();
      int unsigned n;
      int unsigned pop;
      pop = 0;
      next_cells = cells;
      for (int y = 0; y < height; y++) begin
        for (int x = 0; x < width; x++) begin
          n = 0;
          for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
              if (dx != 0 || dy != 0)
                n += cells[(y + dy + height) % height][(x + dx + width) % width];
          next_cells[y][x] = cells[y][x] ? survive[n] : birth[n];
          pop += next_cells[y][x];
        end
      end
      cells = next_cells;
      live = pop;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, int unsigned x, int unsigned y, bit v);
      grid_result_t r;
      bit ok;
      ok = (x < width) && (y < height);
      r.rd = 0;
      r.inr = 0;
      commands_seen++;
      case (cmd)
        CMD_SET: begin
          r.inr = ok;
          if (ok) begin
            live = live - cells[y][x] + v;
            cells[y][x] = v;
          end
        end
        CMD_READ: begin
          r.inr = ok;
          if (ok) r.rd = cells[y][x];
        end
        CMD_ADVANCE: step_generation();
        CMD_INVERT: begin
          for (int yy = 0; yy < height; yy++)
            for (int xx = 0; xx < width; xx++)
              cells[yy][xx] = !cells[yy][xx];
          live = width * height - live;
        end
        CMD_CLEAR: clear_grid();
        default: ;
      endcase
      r.pop = 17'(live);
      expected_q.push_back(r);
    endfunction

    function void check_result(bit rd, bit inr, bit [16:0] pop);
      grid_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("%0t: result with nothing expected (rd %0d inr %0d pop %0d)",
                   $time, rd, inr, pop);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (e.rd !== rd || e.inr !== inr || e.pop !== pop) begin
        failures++;
        if (mismatches < 10)
          $display("%0t: mismatch expected rd %0d inr %0d pop %0d, got rd %0d inr %0d pop %0d",
                   $time, e.rd, e.inr, e.pop, rd, inr, pop);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [REG_W-1:0]  cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  command;
  logic [COL_W-1:0]  x_coord;
  logic [ROW_W-1:0]  y_coord;
  logic              cell_value;
  logic              out_valid;
  logic              out_stall;
  logic              read_value;
  logic              in_range;
  logic [POP_W-1:0]  population;

  life_grid_scoreboard grid_sb;
  int idle_cycles;
  int stall_left;
  bit stall_level;
  bit stall_enable;

  toroidal_life_grid_engine_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .in_range   (in_range),
    .population (population)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: every transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      grid_sb.check_result(read_value, in_range, population);
  end

  // receiver stall: stretches of random length, mostly short, some long, some none
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_level <= stall_enable && ($urandom_range(0, 2) == 0);
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end
  assign out_stall = stall_level;

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", grid_sb.pending());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one command transfer, with a random gap before it
  task automatic send_command(logic [CMD_W-1:0] cmd, int unsigned x, int unsigned y, bit v);
    int gap;
    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command = cmd;
    x_coord = x[7:0];
    y_coord = y[7:0];
    cell_value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    grid_sb.note_command(cmd, x, y, v);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (grid_sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    @(negedge clk);
  endtask

  // register write while the block is idle, then wait out any clearing pass
  task automatic write_register(logic [REG_W-1:0] idx, bit [8:0] d);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    grid_sb.write_reg(idx, d);
    @(negedge clk);
    cfg_write = 1'b0;
    repeat (3) @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // random command mix, coordinates mostly inside the grid
  task automatic random_commands(int count);
    int pick;
    int unsigned x;
    int unsigned y;
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_SET;
      else if (pick < 68) cmd = CMD_READ;
      else if (pick < 84) cmd = CMD_ADVANCE;
      else if (pick < 92) cmd = CMD_INVERT;
      else if (pick < 97) cmd = CMD_FIRST_UNUSED + 3'($urandom_range(0, 2));
      else cmd = CMD_CLEAR;
      x = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, grid_sb.width - 1);
      y = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, grid_sb.height - 1);
      // now and then the sender holds off until every result is back
      if ($urandom_range(0, 19) == 0) wait_drained();
      send_command(cmd, x, y, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    grid_sb = new();
    idle_cycles = 0;
    stall_left = 0;
    stall_level = 1'b0;
    stall_enable = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_SET;
    x_coord = '0;
    y_coord = '0;
    cell_value = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // reset starts a clearing pass
    repeat (3) @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);

    // directed part on the full grid with the default rule
    send_command(CMD_SET, 0, 0, 1'b1);
    send_command(CMD_SET, 255, 255, 1'b1);
    send_command(CMD_SET, 255, 0, 1'b1);
    send_command(CMD_SET, 0, 255, 1'b1);
    send_command(CMD_READ, 255, 255, 1'b0);
    send_command(CMD_READ, 0, 0, 1'b0);
    send_command(CMD_READ, 1, 1, 1'b0);
    send_command(CMD_SET, 0, 0, 1'b0);
    send_command(CMD_SET, 0, 0, 1'b1);
    // blinker straddling the horizontal wrap
    send_command(CMD_SET, 255, 100, 1'b1);
    send_command(CMD_SET, 0, 100, 1'b1);
    send_command(CMD_SET, 1, 100, 1'b1);
    stall_enable = 1'b1;
    send_command(CMD_ADVANCE, 0, 0, 1'b0);
    send_command(CMD_READ, 0, 99, 1'b0);
    send_command(CMD_READ, 0, 101, 1'b0);
    send_command(CMD_READ, 255, 100, 1'b0);
    send_command(CMD_INVERT, 0, 0, 1'b0);
    send_command(CMD_READ, 0, 99, 1'b0);
    send_command(CMD_FIRST_UNUSED, 3, 3, 1'b1);
    send_command(CMD_FIRST_UNUSED + 3'd1, 0, 0, 1'b1);
    send_command(CMD_FIRST_UNUSED + 3'd2, 255, 255, 1'b1);
    send_command(CMD_CLEAR, 0, 0, 1'b0);
    send_command(CMD_READ, 255, 255, 1'b0);
    wait_drained();

    // narrow tall grid: sizes clamp at both ends, rule extremes
    write_register(REG_WIDTH, 9'd0);
    write_register(REG_HEIGHT, 9'd511);
    write_register(REG_WIDTH, 9'd3);
    write_register(REG_BIRTH, 9'd0);
    write_register(REG_SURVIVE, 9'd511);
    send_command(CMD_SET, 4, 0, 1'b1);
    send_command(CMD_SET, 3, 255, 1'b1);
    send_command(CMD_READ, 3, 255, 1'b0);
    random_commands(30);
    wait_drained();

    // tiny grid with the opposite rule extremes
    write_register(REG_WIDTH, 9'd7);
    write_register(REG_HEIGHT, 9'd4);
    write_register(REG_BIRTH, 9'd511);
    write_register(REG_SURVIVE, 9'd0);
    random_commands(30);
    wait_drained();

    // small rectangular grid with random rules
    write_register(REG_WIDTH, 9'd16);
    write_register(REG_HEIGHT, 9'd12);
    write_register(REG_BIRTH, 9'($urandom_range(0, 511)));
    write_register(REG_SURVIVE, 9'($urandom_range(0, 511)));
    random_commands(40);

    while (grid_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (grid_sb.pending() != 0) grid_sb.failures++;
    $display("%0d commands and %0d results on four grid sizes and several rules",
             grid_sb.commands_seen, grid_sb.results_seen);
    $display("%0d mismatches, %0d failures", grid_sb.mismatches, grid_sb.failures);
    if (grid_sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
